// ===== rtl/core/bsef_pkg.sv =====
// bsef_pkg: shared types, codes and helpers for the byte set escape filter
// no dependencies; imported by every module under rtl/core

package bsef_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_MODE  = 3'd0;
  localparam logic [2:0] CFG_MASK0 = 3'd1;
  localparam logic [2:0] CFG_MASK1 = 3'd2;
  localparam logic [2:0] CFG_MASK2 = 3'd3;
  localparam logic [2:0] CFG_MASK3 = 3'd4;

  // escape mode codes
  localparam logic [1:0] MODE_REMOVE  = 2'd0;
  localparam logic [1:0] MODE_BSLASH  = 2'd1;
  localparam logic [1:0] MODE_PERCENT = 2'd2;
  localparam logic [1:0] MODE_PASS    = 2'd3;

  localparam logic [7:0] CHAR_BSLASH  = 8'h5C;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;

  // queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  // what the back end does with a queued byte
  typedef enum logic [1:0] {
    KIND_PASS    = 2'd0,
    KIND_BSLASH  = 2'd1,
    KIND_PERCENT = 2'd2
  } bsef_kind_e;

  typedef struct packed {
    logic [7:0] data;
    bsef_kind_e kind;
  } bsef_item_t;

  // uppercase hex digit for one nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] ext;
    ext = {4'b0000, n};
    if (n < 4'd10) begin
      hex_digit = 8'h30 + ext;
    end else begin
      hex_digit = 8'h37 + ext;
    end
  endfunction

endpackage

// ===== rtl/core/bsef_front.sv =====
// bsef_front: configuration registers and per-byte classification
// depends on bsef_pkg

module bsef_front import bsef_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic [7:0]  in_byte_i,
  input  logic        q_full_i,
  output logic        push_o,
  output bsef_item_t  item_o
);

  logic [1:0]  mode_q;
  logic [63:0] mask_q [4];
  logic        marked;
  logic        drop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_REMOVE;
      for (int i = 0; i < 4; i++) begin
        mask_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MODE:  mode_q    <= cfg_data_i[1:0];
        CFG_MASK0: mask_q[0] <= cfg_data_i;
        CFG_MASK1: mask_q[1] <= cfg_data_i;
        CFG_MASK2: mask_q[2] <= cfg_data_i;
        CFG_MASK3: mask_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign marked = mask_q[in_byte_i[7:6]][in_byte_i[5:0]];

  always_comb begin
    drop         = 1'b0;
    item_o.data  = in_byte_i;
    item_o.kind  = KIND_PASS;
    if (marked) begin
      case (mode_q)
        MODE_REMOVE:  drop        = 1'b1;
        MODE_BSLASH:  item_o.kind = KIND_BSLASH;
        MODE_PERCENT: item_o.kind = KIND_PERCENT;
        default:      item_o.kind = KIND_PASS;
      endcase
    end
  end

  // removed bytes never enter the queue
  assign push_o = in_valid_i && !q_full_i && !drop;

endmodule

// ===== rtl/core/bsef_queue.sv =====
// bsef_queue: two-entry queue of classified bytes between front and back
// depends on bsef_pkg

module bsef_queue import bsef_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  bsef_item_t item_i,
  input  logic       pop_i,
  output logic       full_o,
  output logic       head_valid_o,
  output bsef_item_t head_o
);

  bsef_item_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]       cnt_q, cnt_d;

  assign full_o       = (cnt_q == QCNT_W'(QDEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !head_valid_o))
    else $error("pop from empty queue");

endmodule

// ===== rtl/core/bsef_back.sv =====
// bsef_back: expands the head byte into one to three output beats
// depends on bsef_pkg; holds the output register

module bsef_back import bsef_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  bsef_item_t head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  input  logic       out_stall_i
);

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic [1:0] step_q, step_d;
  logic       load;
  logic [7:0] beat_byte;
  logic       beat_last;

  assign load = head_valid_i && (!out_valid_q || !out_stall_i);

  // byte and last flag for the current step of the head entry
  always_comb begin
    beat_byte = head_i.data;
    beat_last = 1'b1;
    case (head_i.kind)
      KIND_PASS: begin
        beat_byte = head_i.data;
        beat_last = 1'b1;
      end
      KIND_BSLASH: begin
        beat_byte = (step_q == 2'd0) ? CHAR_BSLASH : head_i.data;
        beat_last = (step_q != 2'd0);
      end
      KIND_PERCENT: begin
        case (step_q)
          2'd0:    beat_byte = CHAR_PERCENT;
          2'd1:    beat_byte = hex_digit(head_i.data[7:4]);
          default: beat_byte = hex_digit(head_i.data[3:0]);
        endcase
        beat_last = (step_q == 2'd2);
      end
      default: begin
        beat_byte = head_i.data;
        beat_last = 1'b1;
      end
    endcase
  end

  assign pop_o = load && beat_last;

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (!out_valid_q || !out_stall_i) begin
      out_valid_d = head_valid_i;
    end
    if (load) begin
      step_d = beat_last ? 2'd0 : step_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= beat_byte;
      out_last_q <= beat_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = out_last_q;

  a_mid_item_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != 2'd0) |-> head_valid_i)
    else $error("expansion in progress without a head entry");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |=> out_valid_q)
    else $error("output run broken before its last beat");

endmodule

// ===== rtl/core/byte_set_escape_filter.sv =====
// byte_set_escape_filter: top level, front classifier, queue and back expander
// depends on bsef_pkg, bsef_front, bsef_queue, bsef_back

// Byte set escape filter. One byte enters per input beat; a 256-bit mask
// (registers 1..4, 64 values each) marks a byte set, and register 0 picks what
// happens to a marked byte: 0 drops it, 1 sends a backslash and then the byte,
// 2 sends '%' and two uppercase hex digits, 3 passes everything unchanged.
// Unmarked bytes pass as one beat. run_last_o flags the final output beat of
// each input byte. The front classifies a byte in the cycle it is accepted and
// drops removed bytes at once; kept bytes go into a two-entry queue. The back
// end expands the head entry at one output beat per cycle while the output is
// not stalled, into a registered output stage, and plain bytes flow at one per
// cycle under the same condition. An accepted byte passes through the queue and
// then the output register.
// Configuration writes are always taken (cfg_ready_o is tied high); write them
// only while the block is idle. Indexes above four are ignored.

module byte_set_escape_filter import bsef_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  // input byte channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  // output byte channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o
);

  logic       q_full;
  logic       push;
  bsef_item_t push_item;
  logic       pop;
  logic       head_valid;
  bsef_item_t head_item;

  assign cfg_ready_o = 1'b1;
  // the front stalls only while the queue is full; a removed byte still waits
  // for room, which keeps the stall a plain registered signal
  assign in_stall_o  = q_full;

  bsef_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_byte_i   (in_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .item_o      (push_item)
  );

  // short queue so the front keeps taking bytes while the back expands one
  bsef_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (push_item),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head_item)
  );

  // one output beat per cycle, while the output is not stalled, from the head entry into the output register
  bsef_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .out_stall_i  (out_stall_i)
  );

endmodule

// ===== bench/bsef_checker.sv =====
`timescale 1ns / 1ps
// bsef_checker: watches the config, input and output channels of the byte set
// escape filter, predicts the output beats and compares them; needs bsef_pkg

module bsef_checker import bsef_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  in_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  out_byte_i,
  input  logic        run_last_i,
  output int          beats_due_o,
  output int          mismatch_count_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  logic [1:0]   mode_q;
  logic [255:0] set_mask;
  out_beat_t    due_beats[$];
  int           err_total;

  function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
    string digits = "0123456789ABCDEF";
    return digits[nib];
  endfunction

  // queue up the beats one source byte turns into
  function automatic void expand_byte(input logic [7:0] b);
    if (!set_mask[b] || mode_q == MODE_PASS) begin
      due_beats.push_back('{data: b, last: 1'b1});
    end else if (mode_q == MODE_BSLASH) begin
      due_beats.push_back('{data: CHAR_BSLASH, last: 1'b0});
      due_beats.push_back('{data: b, last: 1'b1});
    end else if (mode_q == MODE_PERCENT) begin
      due_beats.push_back('{data: CHAR_PERCENT, last: 1'b0});
      due_beats.push_back('{data: ascii_hex(b[7:4]), last: 1'b0});
      due_beats.push_back('{data: ascii_hex(b[3:0]), last: 1'b1});
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      mode_q = MODE_REMOVE;
      set_mask = '0;
      due_beats.delete();
      err_total = 0;
      beats_due_o <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MODE:  mode_q = cfg_data_i[1:0];
          CFG_MASK0: set_mask[63:0] = cfg_data_i;
          CFG_MASK1: set_mask[127:64] = cfg_data_i;
          CFG_MASK2: set_mask[191:128] = cfg_data_i;
          CFG_MASK3: set_mask[255:192] = cfg_data_i;
          default: ;
        endcase
      end
      // output first: a beat leaving now belongs to an earlier byte
      if (out_valid_i && !out_stall_i) begin
        if (due_beats.size() == 0) begin
          $display("%0t: unexpected out beat, got byte %02h last %0b",
                   $time, out_byte_i, run_last_i);
          err_total++;
        end else begin
          want = due_beats.pop_front();
          if (want.data !== out_byte_i || want.last !== run_last_i) begin
            $display("%0t: out beat mismatch, expected byte %02h last %0b, got byte %02h last %0b",
                     $time, want.data, want.last, out_byte_i, run_last_i);
            err_total++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expand_byte(in_byte_i);
      end
      beats_due_o <= due_beats.size();
      mismatch_count_o <= err_total;
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// tb: stimulus and verdict for the byte set escape filter
// depends on bsef_pkg, byte_set_escape_filter and bench/bsef_checker

module tb;
  import bsef_pkg::*;

  localparam int HOLD_CYCLES = 60;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = CFG_MODE;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        run_last_o;

  int beats_due;
  int mismatches;

  // knobs shared between the sender and the receiver process
  bit src_gaps = 1'b0;
  bit sink_jitter = 1'b0;
  bit long_hold = 1'b0;

  always #6 clk_i = ~clk_i;

  byte_set_escape_filter i_dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_byte_i,
    .out_valid_o, .out_stall_i, .out_byte_o, .run_last_o
  );

  bsef_checker i_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .in_byte_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_byte_i(out_byte_o),
    .run_last_i(run_last_o),
    .beats_due_o(beats_due), .mismatch_count_o(mismatches)
  );

  // one register beat; valid stays up so back-to-back writes never
  // lower and raise it in the same step, the caller drops it at the end
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // full register load, optionally followed by a write to an unused index
  task automatic program_regs(input logic [1:0] mode, input logic [63:0] m0,
                              input logic [63:0] m1, input logic [63:0] m2,
                              input logic [63:0] m3, input bit poke_unused);
    logic [63:0] mode_word;
    mode_word = {$urandom, $urandom};
    mode_word[1:0] = mode;   // upper bits are junk the block must ignore
    write_reg(CFG_MODE, mode_word);
    write_reg(CFG_MASK0, m0);
    write_reg(CFG_MASK1, m1);
    write_reg(CFG_MASK2, m2);
    write_reg(CFG_MASK3, m3);
    if (poke_unused) begin
      write_reg(CFG_MASK3 + 3'($urandom_range(1, 3)), {$urandom, $urandom});
    end
    cfg_valid_i <= 1'b0;
  endtask

  // offer one byte after an optional idle gap; returns on the accepting edge
  // with valid still high, so the next call or settle() decides what follows
  task automatic push_byte(input logic [7:0] b, input int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // stop sending, wait for every predicted beat, then idle before returning
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (beats_due != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // mask words lean toward the extremes now and then
  function automatic logic [63:0] pick_mask();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // receiver: random stall bursts, or one long hold on request so the
  // block backs up and stalls its input
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        long_hold = 1'b0;
      end else if (sink_jitter && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned gap;
    logic [1:0]  mode_pick;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: empty set, everything passes
    push_byte(8'h00, 0);
    push_byte(8'hFF, 0);
    settle();

    // backslash mode, sparse set: zero, backslash itself and 0xff marked
    program_regs(MODE_BSLASH, 64'h1, 64'h1 << (CHAR_BSLASH - 8'd64), '0,
                 64'h1 << 63, 1'b0);
    push_byte(8'h00, 0);
    push_byte(8'h5C, 0);
    push_byte(8'hFF, 0);
    push_byte(8'h41, 0);
    push_byte(8'h80, 0);
    push_byte(CHAR_PERCENT, 0);
    settle();

    // percent mode, every byte marked; the values cover all sixteen digits
    program_regs(MODE_PERCENT, '1, '1, '1, '1, 1'b0);
    push_byte(8'h00, 0);
    push_byte(8'hFF, 0);
    push_byte(8'h5C, 0);
    push_byte(8'hAB, 0);
    push_byte(8'hCD, 0);
    push_byte(8'hE9, 0);
    push_byte(8'h18, 0);
    push_byte(8'h76, 0);
    push_byte(8'h34, 0);
    push_byte(8'h2F, 0);
    settle();

    // remove mode drops everything marked
    program_regs(MODE_REMOVE, '1, '1, '1, '1, 1'b0);
    push_byte(8'h00, 0);
    push_byte(8'h7F, 0);
    push_byte(8'hFF, 0);
    settle();

    // the unused mode code passes even marked bytes; also poke a dead index
    program_regs(MODE_PASS, '1, '1, '1, '1, 1'b1);
    push_byte(8'h00, 0);
    push_byte(CHAR_BSLASH, 0);
    push_byte(8'hFF, 0);
    settle();

    // random phases with fresh settings each time; the last one runs
    // with no idling on either side
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      mode_pick = 2'($urandom_range(0, 3));
      if (ph == 1) begin
        mode_pick = MODE_PERCENT;   // widest expansion for the back-pressure test
      end
      program_regs(mode_pick, pick_mask(), pick_mask(), pick_mask(), pick_mask(),
                   $urandom_range(0, 2) == 0);
      src_gaps = (ph != 7);
      sink_jitter = (ph != 7) && (ph != 4);
      for (int i = 0; i < 56; i++) begin
        if (ph == 1 && i == 8) begin
          long_hold = 1'b1;
        end
        if (ph == 3 && i == 28) begin
          settle();   // sender pauses until the pipe is empty
        end
        gap = (src_gaps && !long_hold && $urandom_range(0, 3) == 0) ?
              $urandom_range(1, 9) : 0;
        push_byte(8'($urandom_range(0, 255)), gap);
      end
    end

    settle();
    if (mismatches == 0 && beats_due == 0) begin
      $display("byte_set_escape_filter verification clean");
    end else begin
      $display("byte_set_escape_filter verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("byte_set_escape_filter verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bsef_pkg.sv
rtl/core/bsef_front.sv
rtl/core/bsef_queue.sv
rtl/core/bsef_back.sv
rtl/core/byte_set_escape_filter.sv
bench/bsef_checker.sv
bench/tb.sv
